[sv/awp_pkg.sv]
`timescale 1ns / 1ps

package awp_pkg;

  localparam int AngleW   = 15;
  localparam int DiffW    = 16;
  localparam int GainW    = 24;
  localparam int LimitW   = 23;
  localparam int DriveW   = 24;
  localparam int FracBits = 16;
  localparam int PTermW   = 39;
  localparam int DTermW   = 40;
  localparam int ITermW   = 39;
  localparam int IntegW   = 40;
  localparam int SumW     = 42;
  localparam int SatW     = SumW - FracBits;
  localparam int CfgIdxW  = 3;

  localparam logic signed [DiffW-1:0] HalfTurn = 16'sd11520;
  localparam logic signed [DiffW-1:0] FullTurn = 16'sd23040;

  localparam logic [GainW-1:0]  GainPRst  = 24'd98304;
  localparam logic [GainW-1:0]  GainIRst  = 24'd66;
  localparam logic [GainW-1:0]  GainDRst  = 24'd131072;
  localparam logic [LimitW-1:0] IntLimRst = 23'd128;
  localparam logic [LimitW-1:0] DrvLimRst = 23'd3840;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGainP  = 3'd0,
    CfgGainI  = 3'd1,
    CfgGainD  = 3'd2,
    CfgIntLim = 3'd3,
    CfgDrvLim = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]  gain_p;
    logic [GainW-1:0]  gain_i;
    logic [GainW-1:0]  gain_d;
    logic [LimitW-1:0] integral_limit;
    logic [LimitW-1:0] drive_limit;
  } cfg_t;

  // products of one item, passed from the error stage to the sum stage
  typedef struct packed {
    logic              vld;
    logic [AngleW-1:0] wrapped_error;
    logic [PTermW-1:0] pterm;
    logic [DTermW-1:0] dterm;
    logic [ITermW-1:0] iterm;
  } prod_t;

endpackage

[sv/awp_intf.sv]
`timescale 1ns / 1ps

interface awp_in_if;
  import awp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [AngleW-1:0] target_angle;
  logic signed [AngleW-1:0] measured_angle;
  modport source (output valid, target_angle, measured_angle, input ready);
  modport sink (input valid, target_angle, measured_angle, output ready);
endinterface

interface awp_out_if;
  import awp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] drive;
  logic signed [AngleW-1:0] wrapped_error;
  modport source (output valid, drive, wrapped_error, input ready);
  modport sink (input valid, drive, wrapped_error, output ready);
endinterface

interface awp_cfg_if;
  import awp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [GainW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/awp_cfg_regs.sv]
`timescale 1ns / 1ps

module awp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [awp_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  logic [awp_pkg::GainW-1:0]     wr_data_i,
  output awp_pkg::cfg_t                 cfg_o
);
  import awp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_idx_i))
        CfgGainP:  cfg_d.gain_p         = wr_data_i;
        CfgGainI:  cfg_d.gain_i         = wr_data_i;
        CfgGainD:  cfg_d.gain_d         = wr_data_i;
        CfgIntLim: cfg_d.integral_limit = wr_data_i[LimitW-1:0];
        CfgDrvLim: cfg_d.drive_limit    = wr_data_i[LimitW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= GainPRst;
      cfg_q.gain_i         <= GainIRst;
      cfg_q.gain_d         <= GainDRst;
      cfg_q.integral_limit <= IntLimRst;
      cfg_q.drive_limit    <= DrvLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/awp_err_stage.sv]
`timescale 1ns / 1ps

module awp_err_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [awp_pkg::AngleW-1:0] target_i,
  input  logic signed [awp_pkg::AngleW-1:0] measured_i,
  input  awp_pkg::cfg_t                     cfg_i,
  output awp_pkg::prod_t                    prod_o,
  input  logic                              prod_ready_i
);
  import awp_pkg::*;

  logic                     in_vld_q, in_vld_d;
  logic signed [AngleW-1:0] tgt_q, meas_q;
  logic signed [AngleW-1:0] prev_err_q, prev_err_d;
  prod_t                    prod_q, prod_d;
  logic                     prod_vld_d;

  logic                     a_ready, a_move, in_take;
  logic signed [DiffW-1:0]  raw_diff, wrap_diff, d_diff;
  logic signed [AngleW-1:0] err;
  logic signed [PTermW-1:0] pterm;
  logic signed [DTermW-1:0] dterm;
  logic signed [ITermW-1:0] iterm;

  assign a_ready    = !prod_q.vld || prod_ready_i;
  assign a_move     = in_vld_q && a_ready;
  assign in_ready_o = !in_vld_q || a_ready;
  assign in_take    = in_valid_i && in_ready_o;

  // error with one 360 degree wrap
  always_comb begin
    raw_diff = {tgt_q[AngleW-1], tgt_q} - {meas_q[AngleW-1], meas_q};
    if (raw_diff < -HalfTurn) begin
      wrap_diff = raw_diff + FullTurn;
    end else if (raw_diff > HalfTurn) begin
      wrap_diff = raw_diff - FullTurn;
    end else begin
      wrap_diff = raw_diff;
    end
    err    = wrap_diff[AngleW-1:0];
    d_diff = {err[AngleW-1], err} - {prev_err_q[AngleW-1], prev_err_q};
    pterm  = err * $signed({1'b0, cfg_i.gain_p});
    dterm  = d_diff * $signed({1'b0, cfg_i.gain_d});
    iterm  = err * $signed({1'b0, cfg_i.gain_i});
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (a_move) begin
      in_vld_d = 1'b0;
    end

    prod_vld_d = prod_q.vld;
    if (a_move) begin
      prod_vld_d = 1'b1;
    end else if (prod_ready_i) begin
      prod_vld_d = 1'b0;
    end

    prev_err_d = a_move ? err : prev_err_q;

    prod_d               = prod_q;
    prod_d.vld           = prod_vld_d;
    if (a_move) begin
      prod_d.wrapped_error = err;
      prod_d.pterm         = pterm;
      prod_d.dterm         = dterm;
      prod_d.iterm         = iterm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_q     <= '0;
      prev_err_q <= '0;
    end else begin
      in_vld_q   <= in_vld_d;
      prod_q     <= prod_d;
      prev_err_q <= prev_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tgt_q  <= target_i;
      meas_q <= measured_i;
    end
  end

  assign prod_o = prod_q;

endmodule

[sv/awp_sum_stage.sv]
`timescale 1ns / 1ps

module awp_sum_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  awp_pkg::prod_t                    prod_i,
  output logic                              prod_ready_o,
  input  awp_pkg::cfg_t                     cfg_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [awp_pkg::DriveW-1:0] drive_o,
  output logic signed [awp_pkg::AngleW-1:0] wrapped_error_o
);
  import awp_pkg::*;

  logic                     out_vld_q, out_vld_d;
  logic signed [DriveW-1:0] drive_q;
  logic signed [AngleW-1:0] werr_q;
  logic signed [IntegW-1:0] integ_q, integ_d;

  logic                     b_move;
  logic signed [IntegW:0]   acc, ilim, acc_clamped;
  logic signed [SumW-1:0]   sum;
  logic signed [SatW-1:0]   drv_full, dlim, drv_sat;
  logic signed [PTermW-1:0] pterm;
  logic signed [DTermW-1:0] dterm;
  logic signed [ITermW-1:0] iterm;

  assign prod_ready_o = !out_vld_q || out_ready_i;
  assign b_move       = prod_i.vld && prod_ready_o;

  always_comb begin
    pterm = $signed(prod_i.pterm);
    dterm = $signed(prod_i.dterm);
    iterm = $signed(prod_i.iterm);

    // integral with clamp to the limit, which is shifted up by the fraction bits
    acc  = {integ_q[IntegW-1], integ_q} + {{(IntegW+1-ITermW){iterm[ITermW-1]}}, iterm};
    ilim = $signed({{(IntegW+1-LimitW-FracBits){1'b0}}, cfg_i.integral_limit,
                    {FracBits{1'b0}}});
    if (acc > ilim) begin
      acc_clamped = ilim;
    end else if (acc < -ilim) begin
      acc_clamped = -ilim;
    end else begin
      acc_clamped = acc;
    end
    integ_d = b_move ? acc_clamped[IntegW-1:0] : integ_q;

    sum = {{(SumW-PTermW){pterm[PTermW-1]}}, pterm}
        + {{(SumW-DTermW){dterm[DTermW-1]}}, dterm}
        + {{(SumW-IntegW){acc_clamped[IntegW-1]}}, acc_clamped[IntegW-1:0]};

    // dropping fraction bits floors toward minus infinity
    drv_full = sum[SumW-1:FracBits];
    dlim     = $signed({{(SatW-LimitW){1'b0}}, cfg_i.drive_limit});
    if (drv_full > dlim) begin
      drv_sat = dlim;
    end else if (drv_full < -dlim) begin
      drv_sat = -dlim;
    end else begin
      drv_sat = drv_full;
    end

    out_vld_d = out_vld_q;
    if (b_move) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      integ_q   <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      integ_q   <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      drive_q <= drv_sat[DriveW-1:0];
      werr_q  <= $signed(prod_i.wrapped_error);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign drive_o         = drive_q;
  assign wrapped_error_o = werr_q;

endmodule

[sv/angle_wrap_pid_controller.sv]
`timescale 1ns / 1ps
// an accepted item passes through three register stages: input, product and result
// throughput: one item per cycle while the output is ready, set by the input, product and result registers
// each stage advances whenever the stage after it is empty or being emptied
// reset clears previous error, integral sum, all valid flags and loads default gains and limits
module angle_wrap_pid_controller (
  input  logic      clk_i,
  input  logic      rst_ni,
  awp_in_if.sink    in_i,
  awp_out_if.source out_o,
  awp_cfg_if.sink   cfg_i
);
  import awp_pkg::*;

  cfg_t  cfg;
  prod_t prod;
  logic  prod_ready;

  assign cfg_i.ready = 1'b1;

  awp_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  awp_err_stage u_err_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .target_i     (in_i.target_angle),
    .measured_i   (in_i.measured_angle),
    .cfg_i        (cfg),
    .prod_o       (prod),
    .prod_ready_i (prod_ready)
  );

  awp_sum_stage u_sum_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .prod_i          (prod),
    .prod_ready_o    (prod_ready),
    .cfg_i           (cfg),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .drive_o         (out_o.drive),
    .wrapped_error_o (out_o.wrapped_error)
  );

endmodule
